// File: rtl/core/assert_macros.svh
// assertion macros for the checker file
// no dependencies; SHA_ASSERT expects clk and rst_n in scope, SHA_ASSERT_ALWAYS only clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define SHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SHA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/sha1sh_pkg.sv
// sha1sh_pkg: item types and sha-1 constants for the stream hash unit
// no dependencies
package sha1sh_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha1sh_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha1sh_out_t;

  localparam int unsigned NumChain = 5;
  localparam int unsigned NumSched = 16;

  localparam logic [31:0] H_INIT [NumChain] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam logic [2:0]  LAST_WORD_IDX = 3'd4;

endpackage

// File: rtl/core/sha1_stream_hash_unit.sv
// sha1_stream_hash_unit: byte-serial sha-1 hasher, top level; uses sha1sh_pkg
// intake takes one item a cycle while idle; each 64th byte then holds intake through
// the 80 rounds on the one shared round adder and then the chaining add
// end item: padding goes in one byte a cycle up to the block end, each padded
// block is hashed the same way, then five digest items, one a cycle when not stalled
// sync active-low reset loads h0..h4
module sha1_stream_hash_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  sha1sh_pkg::sha1sh_in_t  in_item,
  output logic                    out_valid,
  input  logic                    out_stall,
  output sha1sh_pkg::sha1sh_out_t out_item
);
  import sha1sh_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // taking message items
  localparam logic [2:0] S_PAD   = 3'd1;  // feeding padding and length bytes
  localparam logic [2:0] S_ROUND = 3'd2;  // one sha-1 round a cycle
  localparam logic [2:0] S_ADD   = 3'd3;  // fold working vars into chain
  localparam logic [2:0] S_OUT   = 3'd4;  // hand out digest words

  localparam logic [6:0] LAST_ROUND = 7'd79;

  logic [2:0]  state_r;
  logic [5:0]  bib_r;          // byte position inside the current block
  logic [63:0] bit_count_r;    // message length in bits, wraps
  logic [6:0]  rnd_r;          // round counter
  logic [2:0]  out_idx_r;      // digest word being offered
  logic        end_pending_r;  // end item seen, padding still to come
  logic        mark_sent_r;    // 0x80 already placed
  logic        len_phase_r;    // padding has reached the length field
  logic        final_blk_r;    // the block in flight is the last one
  logic [31:0] h_r [NumChain];

  // payload registers, no reset needed
  logic [23:0] cur_r;            // first three bytes of the word being built
  logic [31:0] sched_r [NumSched];  // rolling schedule, sched_r[0] is oldest
  logic [31:0] a_r, b_r, c_r, d_r, e_r;

  logic        put_en;
  logic [7:0]  put_b;
  logic        blk_full;
  logic [7:0]  len_byte;
  logic        sched_push;
  logic [31:0] sched_in;
  logic [31:0] w_new;
  logic [31:0] w_t;
  logic [31:0] f_t;
  logic [31:0] k_t;
  logic [31:0] temp_t;
  logic        msg_done;

  // length bytes go out most significant first, positions 56 to 63
  assign len_byte = bit_count_r[{~bib_r[2:0], 3'b000} +: 8];

  // byte source: the input item when idle, the padding generator while padding, none otherwise
  always_comb begin
    put_en = 1'b0;
    put_b  = 8'h00;
    case (state_r)
      S_IDLE: begin
        put_en = in_valid & in_item.byte_present;
        put_b  = in_item.msg_byte;
      end
      S_PAD: begin
        put_en = 1'b1;
        if (!mark_sent_r) begin
          put_b = PAD_MARK;
        end else if (len_phase_r) begin
          put_b = len_byte;
        end else begin
          put_b = 8'h00;
        end
      end
      default: begin
        put_en = 1'b0;
        put_b  = 8'h00;
      end
    endcase
  end

  assign blk_full = put_en && (bib_r == 6'd63);

  // schedule expansion taps at fixed places of the rolling window
  always_comb begin
    w_new = sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0];
    w_new = {w_new[30:0], w_new[31]};
    w_t   = (rnd_r < 7'd16) ? sched_r[0] : w_new;
  end

  // round function and constant by round group
  always_comb begin
    if (rnd_r inside {[7'd0:7'd19]}) begin
      f_t = (b_r & c_r) | (~b_r & d_r);
      k_t = K_R0;
    end else if (rnd_r inside {[7'd20:7'd39]}) begin
      f_t = b_r ^ c_r ^ d_r;
      k_t = K_R1;
    end else if (rnd_r inside {[7'd40:7'd59]}) begin
      f_t = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_t = K_R2;
    end else begin
      f_t = b_r ^ c_r ^ d_r;
      k_t = K_R3;
    end
    temp_t = {a_r[26:0], a_r[31:27]} + f_t + e_r + k_t + w_t;
  end

  // the schedule shifts on a completed input word and on every round
  always_comb begin
    sched_push = 1'b0;
    sched_in   = w_t;
    if (state_r == S_ROUND) begin
      sched_push = 1'b1;
      sched_in   = w_t;
    end else if (put_en && (bib_r[1:0] == 2'b11)) begin
      sched_push = 1'b1;
      sched_in   = {cur_r, put_b};
    end
  end

  // last digest item taken: back to the initial state for the next message
  assign msg_done = (state_r == S_OUT) && !out_stall && (out_idx_r == LAST_WORD_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n || msg_done) begin
      state_r       <= S_IDLE;
      bib_r         <= '0;
      bit_count_r   <= '0;
      rnd_r         <= '0;
      out_idx_r     <= '0;
      end_pending_r <= 1'b0;
      mark_sent_r   <= 1'b0;
      len_phase_r   <= 1'b0;
      final_blk_r   <= 1'b0;
      for (int i = 0; i < NumChain; i++) begin
        h_r[i] <= H_INIT[i];
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (put_en) begin
              bib_r       <= bib_r + 6'd1;
              bit_count_r <= bit_count_r + 64'd8;
            end
            if (in_item.end_of_message) begin
              end_pending_r <= 1'b1;
            end
            if (blk_full) begin
              state_r <= S_ROUND;
              rnd_r   <= '0;
            end else if (in_item.end_of_message) begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          bib_r       <= bib_r + 6'd1;
          mark_sent_r <= 1'b1;
          // the length field starts at byte 56 of a block
          if (!len_phase_r && (bib_r == 6'd55)) begin
            len_phase_r <= 1'b1;
          end
          if (len_phase_r && (bib_r == 6'd63)) begin
            final_blk_r <= 1'b1;
          end
          if (blk_full) begin
            state_r <= S_ROUND;
            rnd_r   <= '0;
          end
        end
        S_ROUND: begin
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == LAST_ROUND) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          h_r[0]    <= h_r[0] + a_r;
          h_r[1]    <= h_r[1] + b_r;
          h_r[2]    <= h_r[2] + c_r;
          h_r[3]    <= h_r[3] + d_r;
          h_r[4]    <= h_r[4] + e_r;
          out_idx_r <= '0;
          if (final_blk_r) begin
            state_r <= S_OUT;
          end else if (end_pending_r) begin
            state_r <= S_PAD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_idx_r <= out_idx_r + 3'd1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // word assembly, schedule window and working variables
  always_ff @(posedge clk) begin
    if (put_en) begin
      cur_r <= {cur_r[15:0], put_b};
    end
    if (sched_push) begin
      for (int i = 0; i < NumSched - 1; i++) begin
        sched_r[i] <= sched_r[i + 1];
      end
      sched_r[NumSched - 1] <= sched_in;
    end
    if (blk_full) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (state_r == S_ROUND) begin
      a_r <= temp_t;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  // intake only while idle; results come straight from the chain registers
  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = (state_r == S_OUT);
  assign out_item.digest_word = h_r[out_idx_r];
  assign out_item.word_index  = out_idx_r;
  assign out_item.last_word   = (out_idx_r == LAST_WORD_IDX);

endmodule

// File: rtl/core/sha1sh_checker.sv
// sha1sh_checker: port-level assertions for sha1_stream_hash_unit, bound in below
// depends on sha1sh_pkg and assert_macros.svh
`include "assert_macros.svh"

module sha1sh_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input sha1sh_pkg::sha1sh_in_t  in_item,
  input logic                    out_valid,
  input logic                    out_stall,
  input sha1sh_pkg::sha1sh_out_t out_item
);
  import sha1sh_pkg::*;

  logic in_seen;
  assign in_seen = in_valid && !in_stall && (in_item.byte_present || !in_item.byte_present);

  // a stalled digest item holds
  `SHA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_item), "out item changed while stalled")

  // no intake while digest items are on offer
  `SHA_ASSERT(a_no_in_during_out, out_valid |-> in_stall && !in_seen, "input taken during digest output")

  // digest words follow one another in index order
  `SHA_ASSERT(a_idx_step, out_valid && !out_stall && !out_item.last_word |=> out_valid && (out_item.word_index == 3'($past(out_item.word_index) + 3'd1)), "digest index skipped")

  // taking the last word ends the output and reopens intake
  `SHA_ASSERT(a_last_ends, out_valid && !out_stall && out_item.last_word |=> !out_valid && !in_stall, "block not idle after last digest word")

  // out of reset the block is idle
  `SHA_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "block not idle after reset")

endmodule

bind sha1_stream_hash_unit sha1sh_checker u_sha1sh_checker (.*);

// File: verif/sha1_stream_hash_unit_test.sv
// sha1_stream_hash_unit_test: self-checking bench for the byte-serial sha-1 hasher
// uses sha1sh_pkg for item types and round constants; needs only the rtl
// a scoreboard class keeps its own sha-1 model and matches every digest word in order
module sha1_stream_hash_unit_test;
  import sha1sh_pkg::*;

  // predicts the five digest words of each message and checks them in order
  class sha1_digest_scoreboard;
    logic [31:0] chain [NumChain];
    logic [7:0]  blk [64];
    int unsigned fill;
    logic [63:0] bit_len;
    sha1sh_out_t digests_due [$];
    int unsigned failures;
    int unsigned words_checked;
    int unsigned messages_done;

    function new();
      failures = 0;
      words_checked = 0;
      messages_done = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < NumChain; i++) chain[i] = H_INIT[i];
      fill = 0;
      bit_len = '0;
    endfunction

    // 80 rounds over the buffered block, then the chaining add
    function void mix_block();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 80; i++) begin
        t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
        w[i] = {t[30:0], t[31]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d);
          k = K_R0;
        end else if (i < 40) begin
          f = b ^ c ^ d;
          k = K_R1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K_R2;
        end else begin
          f = b ^ c ^ d;
          k = K_R3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w[i];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void absorb_byte(logic [7:0] v);
      blk[fill] = v;
      fill++;
      if (fill == 64) begin
        mix_block();
        fill = 0;
      end
    endfunction

    // called for every accepted input item
    function void note_item(sha1sh_in_t it);
      logic [63:0] len;
      sha1sh_out_t want;
      if (it.byte_present) begin
        absorb_byte(it.msg_byte);
        bit_len += 64'd8;
      end
      if (!it.end_of_message) return;
      len = bit_len;
      absorb_byte(PAD_MARK);
      while (fill != 56) absorb_byte(8'h00);
      for (int i = 7; i >= 0; i--) absorb_byte(len[i*8 +: 8]);
      for (int i = 0; i < NumChain; i++) begin
        want.digest_word = chain[i];
        want.word_index = 3'(i);
        want.last_word = (3'(i) == LAST_WORD_IDX);
        digests_due = {digests_due, want};
      end
      messages_done++;
      restart();
    endfunction

    function void report(string what);
      failures++;
      if (failures <= 10) $display("  mismatch: %s", what);
    endfunction

    // called for every accepted result item
    function void check_word(sha1sh_out_t got);
      sha1sh_out_t want;
      words_checked++;
      if (digests_due.size() == 0) begin
        report($sformatf("unexpected word %h idx %0d last %0b",
                         got.digest_word, got.word_index, got.last_word));
        return;
      end
      want = digests_due.pop_front();
      if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
          got.last_word !== want.last_word)
        report($sformatf("expected word %h idx %0d last %0b, got word %h idx %0d last %0b",
                         want.digest_word, want.word_index, want.last_word,
                         got.digest_word, got.word_index, got.last_word));
    endfunction

    function int unsigned pending();
      return digests_due.size();
    endfunction
  endclass

  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned IdlePct = 24;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  sha1sh_in_t  in_item;
  logic        out_valid;
  logic        out_stall;
  sha1sh_out_t out_item;

  sha1_digest_scoreboard sb;

  // calm: a stretch with no idling on either side
  // hold_req: asks the receiver for one long hold-off
  bit          calm;
  bit          hold_req;
  int unsigned cycles;
  int unsigned bytes_sent;
  int unsigned items_sent;
  int unsigned blanks_sent;

  sha1_stream_hash_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cycle counter doubles as the watchdog
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d digest words still due", cycles, sb.pending());
    $display("sha1_stream_hash_unit_test: done, errors");
    $finish;
  end

  // receiver: random stalls, a calm stretch, and one long hold-off so that
  // the block backs up and stalls its own input
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = !calm && ($urandom_range(99) < IdlePct);
      end
    end
  end

  // result monitor: sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_item);
  end

  // offers one item, with random idle cycles first; leaves valid high afterwards
  task automatic send_item(input logic [7:0] b, input logic present, input logic eom);
    sha1sh_in_t it;
    it.msg_byte = b;
    it.byte_present = present;
    it.end_of_message = eom;
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid = 1'b0;
      in_item = sha1sh_in_t'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
    if (present) bytes_sent++;
    items_sent++;
    if (!present && !eom) blanks_sent++;
    @(negedge clk);
  endtask

  // random bytes, blank items sprinkled in, the end flag either on the
  // last byte or on a separate item with no byte
  task automatic send_message(input int unsigned len, input bit byte_on_end,
                              input int unsigned blank_pct);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < blank_pct) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, byte_on_end && (i == len - 1));
    end
    if (len == 0 || !byte_on_end) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int unsigned len;
    int unsigned r;
    int unsigned edge_lens [8];
    edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120};
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    bytes_sent = 0;
    items_sent = 0;
    blanks_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty message: a lone end item with no byte
    send_item(8'h00, 1'b0, 1'b1);
    // "abc", the final byte riding on the end item
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // blank items inside a message, extreme byte values, end item without byte
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    // one-byte message on the end item
    send_item(8'hFF, 1'b1, 1'b1);
    // walking bit patterns
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'hFE, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'hAA, 1'b1, 1'b1);

    // random messages; the long hold-off starts straight away
    hold_req = 1'b1;
    while (items_sent < 256) begin
      calm = (items_sent >= 100 && items_sent < 170);
      r = $urandom_range(99);
      if (r < 18) len = edge_lens[$urandom_range(7)];
      else if (r < 30) len = $urandom_range(3);
      else len = $urandom_range(40, 4);
      // last message trimmed so the run stays near its item budget
      if (items_sent + len > 258) len = 258 - items_sent;
      send_message(len, $urandom_range(1), 8);
    end
    calm = 1'b0;
    in_valid = 1'b0;

    // drain, then leave room for any stray word
    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d digest words never arrived", sb.pending()));

    $display("hashed %0d messages (%0d bytes, %0d blank items) incl. empty and block-edge lengths",
             sb.messages_done, bytes_sent, blanks_sent);
    $display("checked %0d digest words through random stalls and a %0d-cycle hold-off, %0d bad",
             sb.words_checked, HoldCycles, sb.failures);
    if (sb.failures == 0) begin
      $display("sha1_stream_hash_unit_test: done, clean");
    end else begin
      $display("sha1_stream_hash_unit_test: done, errors");
    end
    $finish;
  end
endmodule
